[rtl/core/sac_pkg.sv]
// Shared types and constants for the set-associative cache timing block.
// No dependencies.
package sac_pkg;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 32;
  localparam int LAT_W  = 10;
  localparam int CFG_W  = 8;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [STAT_W-1:0] ST_INVALID = 2'd0;
  localparam logic [STAT_W-1:0] ST_VALID   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIRTY   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEM_READ    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_WRITE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_FLUSH   = 2'd2;

  localparam logic [CFG_W-1:0] MEM_READ_RST  = 8'd75;
  localparam logic [CFG_W-1:0] BUF_WRITE_RST = 8'd1;
  localparam logic [CFG_W-1:0] BUF_FLUSH_RST = 8'd20;

  typedef enum logic [1:0] {
    WB_MATCH,
    WB_FREE,
    WB_FLUSH
  } sac_wb_kind_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [TIME_W-1:0] request_time;
    logic [TIME_W-1:0] current_cycle;
  } sac_in_t;

  typedef struct packed {
    logic             hit;
    logic [LAT_W-1:0] latency;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] read_hit_total;
    logic [CNT_W-1:0] write_hit_total;
  } sac_out_t;

endpackage

[rtl/core/sac_tag_store.sv]
// Tag store: one row per set holding all ways, synchronous read, one write port.
// Per-row written bits make never-written rows read as zero. Depends on sac_pkg.
module sac_tag_store
  import sac_pkg::*;
#(
  parameter int SETS  = 4,
  parameter int ROW_W = 120
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [(SETS>1?$clog2(SETS):1)-1:0] rd_addr,
  output logic [ROW_W-1:0]                rd_data,
  input  logic                            wr_en,
  input  logic [(SETS>1?$clog2(SETS):1)-1:0] wr_addr,
  input  logic [ROW_W-1:0]                wr_data
);

  logic [ROW_W-1:0] mem [SETS];
  logic [SETS-1:0]  written_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

[rtl/core/sac_wbuf.sv]
// Tag-only write buffer: lookup, lowest-free-slot insert and full flush.
// Depends on sac_pkg.
module sac_wbuf
  import sac_pkg::*;
#(
  parameter int SLOTS = 4,
  parameter int TAG_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [TAG_W-1:0] tag,
  output sac_wb_kind_t     kind
);

  localparam int SLOT_W = SLOTS > 1 ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] valid_r;
  logic [TAG_W-1:0] tag_r [SLOTS];
  logic             match;
  logic             free;
  logic [SLOT_W-1:0] free_idx;

  always_comb begin
    match    = 1'b0;
    free     = 1'b0;
    free_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (valid_r[s] && tag_r[s] == tag) begin
        match = 1'b1;
      end
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!valid_r[s]) begin
        free     = 1'b1;
        free_idx = SLOT_W'(s);
      end
    end
    if (match) begin
      kind = WB_MATCH;
    end else if (free) begin
      kind = WB_FREE;
    end else begin
      kind = WB_FLUSH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (push) begin
      case (kind)
        WB_FREE: begin
          valid_r[free_idx] <= 1'b1;
        end
        WB_FLUSH: begin
          valid_r <= SLOTS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      case (kind)
        WB_FREE:  tag_r[free_idx] <= tag;
        WB_FLUSH: tag_r[0]        <= tag;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/core/set_assoc_cache_timing_with_write_buffer_top.sv]
// Cache timing top: tag store read-modify-write, write buffer, counters.
// Result: accept registers busy_r, then busy_r registers out_valid and out_data.
// No new access is accepted while busy is high, during the tag store write-back of the row read.
// Results cannot be stalled; out_valid is a one-cycle strobe.
// Reset: registers to defaults, all lines invalid, buffer empty, counters zero.
// Depends on sac_pkg, sac_tag_store, sac_wbuf.
module set_assoc_cache_timing_with_write_buffer_top
  import sac_pkg::*;
#(
  parameter int NUM_SETS     = 4,
  parameter int NUM_WAYS     = 2,
  parameter int LINE_BYTES   = 16,
  parameter int BUFFER_SLOTS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sac_in_t              in_data,
  output logic                 out_valid,
  output sac_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int SB     = $clog2(NUM_SETS);
  localparam int SET_W  = NUM_SETS > 1 ? SB : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - SB;
  localparam int LINE_W = TAG_W + STAT_W + TIME_W;
  localparam int ROW_W  = NUM_WAYS * LINE_W;
  localparam int WAY_W  = NUM_WAYS > 1 ? $clog2(NUM_WAYS) : 1;

  logic [CFG_W-1:0] mem_rd_r, buf_wr_r, buf_fl_r;
  logic             busy_r;
  logic             func_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic [TIME_W-1:0] req_r, now_r;
  logic [CNT_W-1:0] rd_cnt_r, wr_cnt_r, rd_hit_cnt_r, wr_hit_cnt_r;
  logic [CNT_W-1:0] rd_cnt_nxt, wr_cnt_nxt, rd_hit_cnt_nxt, wr_hit_cnt_nxt;
  logic             out_valid_r;
  sac_out_t         out_data_r;

  logic             accept;
  logic [SET_W-1:0] in_set;
  logic [NUM_WAYS-1:0][LINE_W-1:0] row_rd, row_wr;
  logic [TAG_W-1:0]  way_tag  [NUM_WAYS];
  logic [STAT_W-1:0] way_stat [NUM_WAYS];
  logic [TIME_W-1:0] way_time [NUM_WAYS];

  logic             hit;
  logic [WAY_W-1:0] hit_way, victim, sel_way;
  logic [TIME_W-1:0] oldest;
  logic             push;
  sac_wb_kind_t     wb_kind;
  logic [LAT_W-1:0] wb_cost, latency;
  logic [TAG_W-1:0] sel_tag;
  logic [STAT_W-1:0] sel_stat, new_stat;
  logic [TIME_W-1:0] new_time;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign in_set = SET_W'(in_data.address >> OFF_W) & SET_W'(NUM_SETS - 1);

  sac_tag_store #(
    .SETS  (NUM_SETS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (row_rd),
    .wr_en   (busy_r),
    .wr_addr (set_r),
    .wr_data (row_wr)
  );

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_tag[w]  = row_rd[w][TAG_W-1:0];
      way_stat[w] = row_rd[w][TAG_W +: STAT_W];
      way_time[w] = row_rd[w][TAG_W + STAT_W +: TIME_W];
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    victim  = '0;
    oldest  = req_r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && way_stat[w] != ST_INVALID && way_tag[w] == tag_r) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (way_time[w] < oldest) begin
        oldest = way_time[w];
        victim = WAY_W'(w);
      end
    end
  end

  assign sel_way  = hit ? hit_way : victim;
  assign sel_tag  = way_tag[sel_way];
  assign sel_stat = way_stat[sel_way];
  assign push     = busy_r && !hit && sel_stat == ST_DIRTY;

  sac_wbuf #(
    .SLOTS (BUFFER_SLOTS),
    .TAG_W (TAG_W)
  ) u_wbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .tag   (sel_tag),
    .kind  (wb_kind)
  );

  always_comb begin
    wb_cost = '0;
    if (sel_stat == ST_DIRTY) begin
      case (wb_kind)
        WB_FREE:  wb_cost = LAT_W'(buf_wr_r);
        WB_FLUSH: wb_cost = LAT_W'(buf_wr_r) + LAT_W'(buf_fl_r);
        default:  wb_cost = '0;
      endcase
    end
    latency  = hit ? '0 : wb_cost + LAT_W'(mem_rd_r);
    new_time = hit ? now_r : req_r + TIME_W'(latency);
    if (hit) begin
      new_stat = func_r ? ST_DIRTY : sel_stat;
    end else begin
      new_stat = func_r ? ST_DIRTY : ST_VALID;
    end
    row_wr = row_rd;
    row_wr[sel_way] = {new_time, new_stat, hit ? sel_tag : tag_r};
  end

  always_comb begin
    rd_cnt_nxt     = rd_cnt_r + CNT_W'(!func_r);
    wr_cnt_nxt     = wr_cnt_r + CNT_W'(func_r);
    rd_hit_cnt_nxt = rd_hit_cnt_r + CNT_W'(!func_r && hit);
    wr_hit_cnt_nxt = wr_hit_cnt_r + CNT_W'(func_r && hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_rd_r     <= MEM_READ_RST;
      buf_wr_r     <= BUF_WRITE_RST;
      buf_fl_r     <= BUF_FLUSH_RST;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_cnt_r     <= '0;
      wr_cnt_r     <= '0;
      rd_hit_cnt_r <= '0;
      wr_hit_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MEM_READ:  mem_rd_r <= cfg_wdata;
          REG_BUF_WRITE: buf_wr_r <= cfg_wdata;
          REG_BUF_FLUSH: buf_fl_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        rd_cnt_r     <= rd_cnt_nxt;
        wr_cnt_r     <= wr_cnt_nxt;
        rd_hit_cnt_r <= rd_hit_cnt_nxt;
        wr_hit_cnt_r <= wr_hit_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_data.func;
      set_r  <= in_set;
      tag_r  <= TAG_W'(in_data.address >> (OFF_W + SB));
      req_r  <= in_data.request_time;
      now_r  <= in_data.current_cycle;
    end
    if (busy_r) begin
      out_data_r.hit             <= hit;
      out_data_r.latency         <= latency;
      out_data_r.read_total      <= rd_cnt_nxt;
      out_data_r.write_total     <= wr_cnt_nxt;
      out_data_r.read_hit_total  <= rd_hit_cnt_nxt;
      out_data_r.write_hit_total <= wr_hit_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/set_assoc_cache_timing_with_write_buffer_top_tb.sv]
// Self-checking bench for set_assoc_cache_timing_with_write_buffer_top: a queue-fed driver,
// a strobe monitor and a behavioral cache timing predictor compared field by field.
// Depends on sac_pkg and the top level.
module set_assoc_cache_timing_with_write_buffer_top_tb;
  import sac_pkg::*;

  localparam int NUM_SETS     = 4;
  localparam int NUM_WAYS     = 2;
  localparam int BUFFER_SLOTS = 4;
  localparam int OFS_W        = 4;
  localparam int SET_W        = 2;
  localparam int TAG_W        = ADDR_W - OFS_W - SET_W;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 95;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           start = 1'b0;
  logic           busy;
  sac_in_t        in_data = '0;
  logic           out_valid;
  sac_out_t       out_data;
  logic           cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  set_assoc_cache_timing_with_write_buffer_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [TAG_W-1:0]  tag_store   [NUM_SETS][NUM_WAYS] = '{default: '0};
  logic [STAT_W-1:0] stat_store  [NUM_SETS][NUM_WAYS] = '{default: ST_INVALID};
  logic [TIME_W-1:0] ready_store [NUM_SETS][NUM_WAYS] = '{default: '0};
  logic [TAG_W-1:0]  wb_tag      [BUFFER_SLOTS] = '{default: '0};
  logic              wb_used     [BUFFER_SLOTS] = '{default: 1'b0};
  logic [CNT_W-1:0]  rd_total = '0, wr_total = '0, rd_hit_total = '0, wr_hit_total = '0;
  logic [CFG_W-1:0]  mem_rd_lat = MEM_READ_RST;
  logic [CFG_W-1:0]  buf_wr_lat = BUF_WRITE_RST;
  logic [CFG_W-1:0]  buf_flush_lat = BUF_FLUSH_RST;

  sac_in_t     access_q[$];
  sac_out_t    result_q[$];
  sac_out_t    want, model_res;
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 17;
  int unsigned tstamp = 0;
  logic [TAG_W-1:0] tag_pool [5];

  task automatic cache_access(input sac_in_t acc, output sac_out_t res);
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] oldest;
    logic [LAT_W-1:0]  lat;
    sac_wb_kind_t      kind;
    int                victim, way, free_slot;
    set_idx = acc.address[OFS_W +: SET_W];
    tag     = acc.address[ADDR_W-1 -: TAG_W];
    oldest  = acc.request_time;
    lat     = '0;
    victim  = 0;
    way     = -1;
    for (int w = 0; w < NUM_WAYS && way < 0; w++) begin
      if (stat_store[set_idx][w] != ST_INVALID && tag_store[set_idx][w] == tag) begin
        way = w;
      end else if (ready_store[set_idx][w] < oldest) begin
        oldest = ready_store[set_idx][w];
        victim = w;
      end
    end
    if (way >= 0) begin
      ready_store[set_idx][way] = acc.current_cycle;
      if (acc.func) begin
        wr_total++;
        wr_hit_total++;
        stat_store[set_idx][way] = ST_DIRTY;
      end else begin
        rd_total++;
        rd_hit_total++;
      end
    end else begin
      if (stat_store[set_idx][victim] == ST_DIRTY) begin
        kind = WB_FLUSH;
        free_slot = 0;
        for (int s = BUFFER_SLOTS - 1; s >= 0; s--) begin
          if (!wb_used[s]) begin
            kind = WB_FREE;
            free_slot = s;
          end
        end
        for (int s = 0; s < BUFFER_SLOTS; s++) begin
          if (wb_used[s] && wb_tag[s] == tag_store[set_idx][victim]) kind = WB_MATCH;
        end
        case (kind)
          WB_MATCH: lat = '0;
          WB_FREE: begin
            wb_used[free_slot] = 1'b1;
            wb_tag[free_slot]  = tag_store[set_idx][victim];
            lat = LAT_W'(buf_wr_lat);
          end
          default: begin
            for (int s = 0; s < BUFFER_SLOTS; s++) wb_used[s] = 1'b0;
            wb_used[0] = 1'b1;
            wb_tag[0]  = tag_store[set_idx][victim];
            lat = LAT_W'(buf_flush_lat) + LAT_W'(buf_wr_lat);
          end
        endcase
      end
      lat = lat + LAT_W'(mem_rd_lat);
      if (acc.func) begin
        wr_total++;
        stat_store[set_idx][victim] = ST_DIRTY;
      end else begin
        rd_total++;
        stat_store[set_idx][victim] = ST_VALID;
      end
      tag_store[set_idx][victim]   = tag;
      ready_store[set_idx][victim] = acc.request_time + TIME_W'(lat);
    end
    res.hit             = (way >= 0);
    res.latency         = lat;
    res.read_total      = rd_total;
    res.write_total     = wr_total;
    res.read_hit_total  = rd_hit_total;
    res.write_hit_total = wr_hit_total;
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // driver: an item stays on the ports until its transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (accepted_cnt != queued_cnt - access_q.size()) begin
      start <= 1'b1;
    end else if (access_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      start   <= 1'b1;
      in_data <= access_q.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_data.hit));
          check_field("latency", 32'(want.latency), 32'(out_data.latency));
          check_field("read_total", want.read_total, out_data.read_total);
          check_field("write_total", want.write_total, out_data.write_total);
          check_field("read_hit_total", want.read_hit_total, out_data.read_hit_total);
          check_field("write_hit_total", want.write_hit_total, out_data.write_hit_total);
        end
      end
      if (start && !busy) begin
        cache_access(in_data, model_res);
        result_q.push_back(model_res);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("set_assoc_cache_timing_with_write_buffer_top verification failed");
      $finish;
    end
  end

  task automatic add_access(logic func, logic [31:0] addr, logic [31:0] req, logic [31:0] cur);
    sac_in_t acc;
    acc.func          = func;
    acc.address       = addr;
    acc.request_time  = req;
    acc.current_cycle = cur;
    access_q.push_back(acc);
    queued_cnt++;
  endtask

  function automatic logic [31:0] line_addr(logic [TAG_W-1:0] tag, logic [SET_W-1:0] set_idx);
    return {tag, set_idx, OFS_W'(0)};
  endfunction

  task automatic add_random(int unsigned n);
    logic [31:0] addr, req, cur;
    int unsigned k;
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom);
    repeat (n) begin
      if ($urandom_range(0, 99) < 80) begin
        addr = {tag_pool[$urandom_range(0, 4)], SET_W'($urandom), OFS_W'($urandom)};
      end else begin
        addr = $urandom;
      end
      tstamp += $urandom_range(0, 120);
      k = $urandom_range(0, 99);
      if (k < 85) req = tstamp;
      else if (k < 92) req = $urandom;
      else if (k < 96) req = '0;
      else req = '1;
      cur = ($urandom_range(0, 99) < 85) ? tstamp + $urandom_range(0, 40) : $urandom;
      add_access(1'($urandom_range(0, 1)), addr, req, cur);
    end
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    case (idx)
      REG_MEM_READ:  mem_rd_lat = val;
      REG_BUF_WRITE: buf_wr_lat = val;
      REG_BUF_FLUSH: buf_flush_lat = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_latencies(logic [CFG_W-1:0] rd, logic [CFG_W-1:0] wr, logic [CFG_W-1:0] fl);
    write_cfg(REG_MEM_READ, rd);
    write_cfg(REG_BUF_WRITE, wr);
    write_cfg(REG_BUF_FLUSH, fl);
  endtask

  task automatic drain();
    while (accepted_cnt != queued_cnt || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed part, reset latencies
    add_access(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_access(1'b1, 32'h0000_000C, 32'd100, 32'hFFFF_FFFF);
    add_access(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    add_access(1'b0, 32'hFFFF_FFF0, 32'd5, 32'd5);
    for (int t = 1; t <= 6; t++) begin
      add_access(1'b1, line_addr(TAG_W'(t), 2'd0), 32'(1000 * t), 32'(1000 * t));
    end
    add_access(1'b1, line_addr(TAG_W'(5), 2'd1), 32'd10000, 32'd10000);
    add_access(1'b0, line_addr(TAG_W'(9), 2'd1), 32'd11000, 32'd11000);
    add_access(1'b0, line_addr(TAG_W'(10), 2'd1), 32'd12000, 32'd12000);
    add_access(1'b0, line_addr(TAG_W'(10), 2'd1), 32'd12500, 32'd12600);
    add_access(1'b0, 32'hAAAA_AAAA, 32'h8000_0000, 32'h5555_5555);
    add_access(1'b1, 32'h5555_5555, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    add_access(1'b1, 32'h5555_5555, 32'h8000_0010, 32'h8000_0010);
    drain();

    set_latencies('0, '0, '0);
    add_random(PHASE_ITEMS);
    drain();

    idle_pct = 69;
    set_latencies('1, '1, '1);
    add_random(PHASE_ITEMS);
    drain();

    set_latencies(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    add_random(PHASE_ITEMS);
    drain();

    idle_pct = 0;
    set_latencies(MEM_READ_RST, BUF_WRITE_RST, BUF_FLUSH_RST);
    add_random(PHASE_ITEMS);
    drain();

    set_latencies(CFG_W'($urandom), '0, '1);
    add_random(PHASE_ITEMS);
    drain();

    if (errors == 0) begin
      $display("set_assoc_cache_timing_with_write_buffer_top verification clean");
    end else begin
      $display("set_assoc_cache_timing_with_write_buffer_top verification failed");
    end
    $finish;
  end

endmodule
